// ----- hdl/rfpc_pkg.sv -----
package rfpc_pkg;

    // field types
    typedef logic [1:0]  t_button;
    typedef logic [31:0] t_time;
    typedef logic [6:0]  t_vol;
    typedef logic [10:0] t_freq;
    typedef logic [2:0]  t_stn;
    typedef logic [2:0]  t_cfg_idx;
    typedef logic [15:0] t_cfg_data;
    typedef logic [7:0]  t_step;

    // band, volume and station constants
    localparam t_freq BAND_LOW   = 11'd875;
    localparam t_freq BAND_HIGH  = 11'd1080;
    localparam t_step BAND_STEPS = 8'd206;
    localparam t_vol  VOL_MAX    = 7'd100;
    localparam t_vol  VOL_BIG    = 7'd5;
    localparam t_vol  VOL_RESET  = 7'd50;
    localparam t_stn  NO_STATION = 3'd5;

    // register reset values
    localparam t_cfg_data DEBOUNCE_RESET = 16'd50;
    localparam t_cfg_data LONG_RESET     = 16'd1000;
    localparam int        MAX_PRESETS    = 5;
    localparam t_freq PRESET_RESET [MAX_PRESETS] = '{11'd881, 11'd895, 11'd909,
                                                    11'd921, 11'd929};

    // register indexes
    localparam t_cfg_idx REG_DEBOUNCE = 3'd0;
    localparam t_cfg_idx REG_LONG     = 3'd1;
    localparam t_cfg_idx REG_PRESET0  = 3'd2;

    // button codes
    localparam t_button BTN_TUNE_DN = 2'd0;
    localparam t_button BTN_TUNE_UP = 2'd1;
    localparam t_button BTN_VOL_DN  = 2'd2;
    localparam t_button BTN_VOL_UP  = 2'd3;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEB  = 6'b000010,
        S_LEN  = 6'b000100,
        S_ACT  = 6'b001000,
        S_SEEK = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

// ----- hdl/radio_front_panel_controller.sv -----
// Channel | Direction | Signals
// --------+-----------+---------------------------------------------------------
// in      | sink      | i_in_valid, o_in_ready, i_button, i_time_ms
// out     | source    | o_out_valid, i_out_ready, o_volume_level, o_tuned_freq,
//         |           | o_station_index, o_seek_failed
// cfg     | sink      | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// A press or a bounced edge passes S_DEB and returns to idle; a short release
// or a volume action passes S_DEB, S_LEN, S_ACT and S_DONE, its result then
// held in the output register; a long tune release adds S_SEEK, up to
// BAND_STEPS band steps, one per cycle through the shared step/compare unit.
// One 32-bit subtractor serves both the debounce and the press length checks.
// Synchronous active-low reset restores the config, sequencer, panel and output
// valid registers. A result waits in the output register; the sequencer holds
// its last state while that register is full, and takes input only when idle.
module radio_front_panel_controller #(
    parameter int NUM_PRESETS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rfpc_pkg::t_button    i_button,
    input  rfpc_pkg::t_time      i_time_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rfpc_pkg::t_vol       o_volume_level,
    output rfpc_pkg::t_freq      o_tuned_freq,
    output rfpc_pkg::t_stn       o_station_index,
    output logic                 o_seek_failed,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  rfpc_pkg::t_cfg_idx   i_cfg_index,
    input  rfpc_pkg::t_cfg_data  i_cfg_data
);
    import rfpc_pkg::*;

    // match index of f against the active presets, highest index wins
    function automatic t_stn station_of(input t_freq f, input t_freq p [NUM_PRESETS]);
        t_stn idx;
        idx = NO_STATION;
        for (int i = 0; i < NUM_PRESETS; i++) begin
            if (p[i] == f) idx = t_stn'(i);
        end
        return idx;
    endfunction

    t_state    r_state;
    t_cfg_data r_debounce;
    t_cfg_data r_long_ms;
    t_freq     r_preset [NUM_PRESETS];

    logic      r_pressed;
    t_time     r_press_start;
    t_time     r_last_accept;
    t_vol      r_vol;
    t_freq     r_freq;

    t_button   r_button;
    t_time     r_time;
    logic      r_long;
    logic      r_failed;
    t_freq     r_seek_f;
    t_step     r_step;

    logic      r_out_valid;
    t_vol      r_out_vol;
    t_freq     r_out_freq;
    t_stn      r_out_stn;
    logic      r_out_failed;

    t_time     diff;
    t_freq     n_seek_f;
    logic      seek_wrap;
    logic      seek_hit;
    t_stn      seek_stn;
    t_stn      done_stn;
    logic      out_free;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_volume_level  = r_out_vol;
    assign o_tuned_freq    = r_out_freq;
    assign o_station_index = r_out_stn;
    assign o_seek_failed   = r_out_failed;

    assign out_free = !r_out_valid || i_out_ready;

    // shared subtractor: debounce gap, then press length
    assign diff = r_time - ((r_state == S_DEB) ? r_last_accept : r_press_start);

    // seek step unit: one band step and a compare against all presets
    always_comb begin
        seek_wrap = 1'b0;
        if (r_button == BTN_TUNE_UP) begin
            if (r_seek_f + 11'd1 >= BAND_HIGH) begin
                n_seek_f  = BAND_LOW;
                seek_wrap = 1'b1;
            end else begin
                n_seek_f = r_seek_f + 11'd1;
            end
        end else begin
            if (r_seek_f <= BAND_LOW + 11'd1) begin
                n_seek_f  = BAND_HIGH;
                seek_wrap = 1'b1;
            end else begin
                n_seek_f = r_seek_f - 11'd1;
            end
        end
        seek_stn = station_of(n_seek_f, r_preset);
        seek_hit = !seek_wrap && (seek_stn != NO_STATION);
    end

    assign done_stn = station_of(r_freq, r_preset);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_long_ms  <= LONG_RESET;
            for (int i = 0; i < NUM_PRESETS; i++) begin
                r_preset[i] <= PRESET_RESET[i];
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_DEBOUNCE) r_debounce <= i_cfg_data;
            if (i_cfg_index == REG_LONG)     r_long_ms  <= i_cfg_data;
            for (int i = 0; i < NUM_PRESETS; i++) begin
                if (i_cfg_index == REG_PRESET0 + t_cfg_idx'(i)) begin
                    r_preset[i] <= i_cfg_data[10:0];
                end
            end
        end
    end

    // sequencer and panel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pressed     <= 1'b0;
            r_press_start <= '0;
            r_last_accept <= '0;
            r_vol         <= VOL_RESET;
            r_freq        <= BAND_LOW;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_button <= i_button;
                        r_time   <= i_time_ms;
                        r_state  <= S_DEB;
                    end
                end
                S_DEB: begin
                    if (diff < {16'd0, r_debounce}) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_last_accept <= r_time;
                        if (!r_pressed) begin
                            r_pressed     <= 1'b1;
                            r_press_start <= r_time;
                            r_state       <= S_IDLE;
                        end else begin
                            r_pressed <= 1'b0;
                            r_state   <= S_LEN;
                        end
                    end
                end
                S_LEN: begin
                    r_long  <= (diff >= {16'd0, r_long_ms});
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    r_failed <= 1'b0;
                    r_seek_f <= r_freq;
                    r_step   <= '0;
                    r_state  <= S_DONE;
                    unique case (r_button)
                        BTN_TUNE_DN: begin
                            if (r_long) r_state <= S_SEEK;
                            else r_freq <= (r_freq > BAND_LOW) ? r_freq - 11'd1 : BAND_HIGH;
                        end
                        BTN_TUNE_UP: begin
                            if (r_long) r_state <= S_SEEK;
                            else r_freq <= (r_freq < BAND_HIGH) ? r_freq + 11'd1 : BAND_LOW;
                        end
                        BTN_VOL_DN: begin
                            if (r_long) r_vol <= (r_vol >= VOL_BIG) ? r_vol - VOL_BIG : '0;
                            else if (r_vol != '0) r_vol <= r_vol - 7'd1;
                        end
                        BTN_VOL_UP: begin
                            if (r_long) begin
                                r_vol <= (r_vol + VOL_BIG <= VOL_MAX) ? r_vol + VOL_BIG : VOL_MAX;
                            end else if (r_vol < VOL_MAX) begin
                                r_vol <= r_vol + 7'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SEEK: begin
                    if (seek_hit) begin
                        r_freq  <= n_seek_f;
                        r_state <= S_DONE;
                    end else if (r_step == BAND_STEPS - 8'd1) begin
                        r_failed <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_step   <= r_step + 8'd1;
                        r_seek_f <= n_seek_f;
                    end
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_vol    <= r_vol;
            r_out_freq   <= r_freq;
            r_out_stn    <= done_stn;
            r_out_failed <= r_failed;
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import rfpc_pkg::*;

    localparam int     N_PRESETS    = 5;
    localparam int     IDLE_MAX     = 16;
    localparam int     SETTLE_CYC   = 40;
    localparam int     RANDOM_EDGES = 850;
    localparam int     N_PHASES     = 8;
    localparam int     MAX_REPORTS  = 10;
    localparam longint TIMEOUT_NS   = 4_000_000;
    // index that maps to no register; writes to it must be ignored
    localparam t_cfg_idx REG_UNUSED = 3'd7;

    typedef struct packed {
        t_vol  vol;
        t_freq freq;
        t_stn  stn;
        logic  failed;
    } t_panel_result;

    // Predicts the panel state per accepted button edge, checks released actions
    class panel_scoreboard;
        t_cfg_data     debounce_ms;
        t_cfg_data     long_ms;
        t_freq         preset [N_PRESETS];
        logic          pressed;
        t_time         press_start;
        t_time         last_accept;
        t_vol          vol;
        t_freq         freq;
        t_panel_result action_q [$];
        int            mismatches;

        function new();
            debounce_ms = DEBOUNCE_RESET;
            long_ms     = LONG_RESET;
            for (int i = 0; i < N_PRESETS; i++) preset[i] = PRESET_RESET[i];
            pressed     = 1'b0;
            press_start = '0;
            last_accept = '0;
            vol         = VOL_RESET;
            freq        = BAND_LOW;
            mismatches  = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data data);
            if (idx == REG_DEBOUNCE) begin
                debounce_ms = data;
            end else if (idx == REG_LONG) begin
                long_ms = data;
            end else if (idx >= REG_PRESET0 && idx < REG_PRESET0 + N_PRESETS) begin
                preset[int'(idx) - int'(REG_PRESET0)] = data[10:0];
            end
        endfunction

        // highest matching preset wins
        function t_stn station_at(t_freq f);
            t_stn idx;
            idx = NO_STATION;
            for (int i = 0; i < N_PRESETS; i++)
                if (preset[i] == f) idx = t_stn'(i);
            return idx;
        endfunction

        // one lap of the band; wrapping steps are not compared
        function bit seek_station(bit up);
            t_freq f;
            f = freq;
            for (int s = 0; s < int'(BAND_STEPS); s++) begin
                if (up) begin
                    if (f + 11'd1 >= BAND_HIGH) begin
                        f = BAND_LOW;
                        continue;
                    end
                    f = f + 11'd1;
                end else begin
                    if (f <= BAND_LOW + 11'd1) begin
                        f = BAND_HIGH;
                        continue;
                    end
                    f = f - 11'd1;
                end
                if (station_at(f) != NO_STATION) begin
                    freq = f;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_edge(t_button btn, t_time t);
            t_time         since;
            t_time         held;
            bit            is_long;
            bit            failed;
            t_panel_result r;
            since = t - last_accept;
            if (since < debounce_ms) return;
            last_accept = t;
            if (!pressed) begin
                pressed     = 1'b1;
                press_start = t;
                return;
            end
            pressed = 1'b0;
            held    = t - press_start;
            is_long = (held >= long_ms);
            failed  = 1'b0;
            case (btn)
                BTN_TUNE_DN: begin
                    if (is_long) failed = !seek_station(1'b0);
                    else freq = (freq > BAND_LOW) ? freq - 11'd1 : BAND_HIGH;
                end
                BTN_TUNE_UP: begin
                    if (is_long) failed = !seek_station(1'b1);
                    else freq = (freq < BAND_HIGH) ? freq + 11'd1 : BAND_LOW;
                end
                BTN_VOL_DN: begin
                    if (is_long) vol = (vol >= VOL_BIG) ? vol - VOL_BIG : '0;
                    else if (vol != 0) vol = vol - 7'd1;
                end
                default: begin
                    if (is_long) vol = (int'(vol) + int'(VOL_BIG) <= int'(VOL_MAX)) ?
                                       vol + VOL_BIG : VOL_MAX;
                    else if (vol < VOL_MAX) vol = vol + 7'd1;
                end
            endcase
            r.vol    = vol;
            r.freq   = freq;
            r.stn    = station_at(freq);
            r.failed = failed;
            action_q.push_back(r);
        endfunction

        function void check_result(t_panel_result got);
            t_panel_result want;
            if (action_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result beat: vol=%0d freq=%0d stn=%0d fail=%0d",
                             got.vol, got.freq, got.stn, got.failed);
                mismatches++;
                return;
            end
            want = action_q.pop_front();
            if (got.vol !== want.vol || got.freq !== want.freq ||
                got.stn !== want.stn || got.failed !== want.failed) begin
                if (mismatches < MAX_REPORTS) begin
                    $write("mismatch: exp vol=%0d freq=%0d stn=%0d fail=%0d, ",
                           want.vol, want.freq, want.stn, want.failed);
                    $display("got vol=%0d freq=%0d stn=%0d fail=%0d",
                             got.vol, got.freq, got.stn, got.failed);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return action_q.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_button   i_button;
    t_time     i_time_ms;
    logic      o_out_valid;
    logic      i_out_ready;
    t_vol      o_volume_level;
    t_freq     o_tuned_freq;
    t_stn      o_station_index;
    logic      o_seek_failed;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_data;

    panel_scoreboard sb;
    bit              no_idle;
    int              edges_sent;

    radio_front_panel_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_button        (i_button),
        .i_time_ms       (i_time_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_volume_level  (o_volume_level),
        .o_tuned_freq    (o_tuned_freq),
        .o_station_index (o_station_index),
        .o_seek_failed   (o_seek_failed),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // one button edge beat; valid stays up after acceptance until the next negedge
    task send_edge(t_button btn, t_time t);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_button   = btn;
        i_time_ms  = t;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_edge(btn, t);
        edges_sent++;
    endtask

    task write_reg(t_cfg_idx idx, t_cfg_data data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // drain results, then let a pending press or bounce finish
    task wait_quiet();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function t_button any_button();
        return t_button'($urandom_range(0, 3));
    endfunction

    // press then release; optional bounce while held
    task press_release(t_button btn, bit want_long, bit bounce);
        int unsigned deb;
        int unsigned lng;
        int unsigned len;
        int unsigned lo;
        t_time       t_press;
        deb     = sb.debounce_ms;
        lng     = sb.long_ms;
        t_press = sb.last_accept + deb + $urandom_range(0, 100);
        send_edge(any_button(), t_press);
        if (bounce && deb > 0)
            send_edge(any_button(), t_press + $urandom_range(0, deb - 1));
        if (!want_long && lng > deb) begin
            len = ($urandom_range(0, 7) == 0) ? lng - 1 : $urandom_range(deb, lng - 1);
        end else begin
            lo  = (lng > deb) ? lng : deb;
            len = lo + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 300));
        end
        send_edge(btn, t_press + len);
    endtask

    function t_cfg_data any_preset();
        if ($urandom_range(0, 5) == 0) return t_cfg_data'($urandom());
        return t_cfg_data'($urandom_range(int'(BAND_LOW), int'(BAND_HIGH)));
    endfunction

    task write_presets(t_cfg_data a, t_cfg_data b, t_cfg_data c, t_cfg_data d,
                       t_cfg_data e);
        write_reg(REG_PRESET0,                  a);
        write_reg(REG_PRESET0 + t_cfg_idx'(1), b);
        write_reg(REG_PRESET0 + t_cfg_idx'(2), c);
        write_reg(REG_PRESET0 + t_cfg_idx'(3), d);
        write_reg(REG_PRESET0 + t_cfg_idx'(4), e);
    endtask

    // register setting for each random phase; the first few hit the extremes
    task apply_setting(int k);
        case (k)
            1: begin
                write_reg(REG_DEBOUNCE, 16'd0);
                write_reg(REG_LONG, 16'd0);
                write_presets(any_preset(), any_preset(), any_preset(), any_preset(),
                              any_preset());
            end
            2: begin
                write_reg(REG_DEBOUNCE, 16'hFFFF);
                write_reg(REG_LONG, 16'hFFFF);
            end
            3: begin
                // nothing reachable by a seek: band ends and out-of-band values
                write_reg(REG_DEBOUNCE, 16'd20);
                write_reg(REG_LONG, 16'd300);
                write_presets(16'd875, 16'd1080, 16'hFFFF, 16'h0000, 16'd1080);
                write_reg(REG_UNUSED, t_cfg_data'($urandom()));
            end
            4: begin
                // duplicates report the highest index
                write_reg(REG_DEBOUNCE, t_cfg_data'($urandom_range(0, 200)));
                write_reg(REG_LONG, t_cfg_data'($urandom_range(0, 1500)));
                write_presets(16'd1000, 16'd1000, 16'd950, 16'd1000, 16'd950);
            end
            5: begin
                write_reg(REG_DEBOUNCE, 16'd30);
                write_reg(REG_LONG, 16'd200);
                write_presets(16'd876, 16'd1079, 16'd876, 16'd1079, 16'd1000);
            end
            default: begin
                write_reg(REG_DEBOUNCE, ($urandom_range(0, 7) == 0) ?
                          t_cfg_data'($urandom()) : t_cfg_data'($urandom_range(0, 200)));
                write_reg(REG_LONG, ($urandom_range(0, 7) == 0) ?
                          t_cfg_data'($urandom()) : t_cfg_data'($urandom_range(0, 1500)));
                write_presets(any_preset(), any_preset(), any_preset(), any_preset(),
                              any_preset());
            end
        endcase
    endtask

    // mostly clean press/release pairs, some bounces, some raw noise
    task random_phase(int quota);
        int      stop_at;
        int      pick;
        bit      biased;
        t_button favored;
        t_button btn;
        stop_at = edges_sent + quota;
        biased  = ($urandom_range(0, 1) == 1);
        favored = any_button();
        // one anchor near the top of the tick counter so times wrap
        if ($urandom_range(0, 1) == 1)
            send_edge(any_button(), 32'hFFFF_F000 + $urandom_range(0, 4095));
        while (edges_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            btn  = (biased && $urandom_range(0, 1) == 1) ? favored : any_button();
            if (pick < 88) begin
                press_release(btn, $urandom_range(0, 1) == 1, $urandom_range(0, 5) == 0);
            end else begin
                send_edge(btn, t_time'($urandom()));
            end
        end
    endtask

    // result side: random stall per beat
    initial begin
        int            stall;
        t_panel_result got;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap();
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
            end
            @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.vol    = o_volume_level;
            got.freq   = o_tuned_freq;
            got.stn    = o_station_index;
            got.failed = o_seek_failed;
            sb.check_result(got);
        end
    end

    // main sequence
    initial begin
        sb          = new();
        no_idle     = 1'b0;
        edges_sent  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_button    = BTN_TUNE_DN;
        i_time_ms   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_DEBOUNCE;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset settings: debounce 50, long 1000
        send_edge(BTN_VOL_UP, 32'd1000);
        send_edge(BTN_TUNE_DN, 32'd1100);            // short down wraps to top
        send_edge(BTN_VOL_UP, 32'd1200);
        send_edge(BTN_TUNE_UP, 32'd1300);            // short up wraps to bottom
        send_edge(BTN_VOL_DN, 32'd1400);
        send_edge(BTN_TUNE_UP, 32'd2400);            // exactly long: seek up
        send_edge(BTN_VOL_DN, 32'd2500);
        send_edge(BTN_TUNE_DN, 32'd3600);            // seek down across the wrap
        send_edge(BTN_TUNE_DN, 32'd3700);
        send_edge(BTN_VOL_UP, 32'd3800);
        send_edge(BTN_TUNE_UP, 32'd3900);
        send_edge(BTN_VOL_UP, 32'd5000);             // long volume up
        send_edge(BTN_TUNE_DN, 32'd5050);            // exactly the debounce time
        send_edge(BTN_VOL_DN, 32'd5150);
        send_edge(BTN_VOL_UP, 32'd5250);
        send_edge(BTN_VOL_DN, 32'd6249);             // one short of long
        send_edge(BTN_TUNE_UP, 32'd6400);
        send_edge(BTN_TUNE_DN, 32'd6449);            // bounce, dropped
        send_edge(BTN_VOL_DN, 32'd7500);             // long volume down
        send_edge(BTN_VOL_UP, 32'hFFFF_FE00);
        send_edge(BTN_TUNE_UP, 32'h0000_0100);       // press spans the counter wrap
        send_edge(BTN_VOL_DN, 32'hFFFF_FFFF);
        send_edge(BTN_TUNE_UP, 32'h0000_0031);       // 50 ticks across the wrap
        wait_quiet();

        for (int k = 1; k <= N_PHASES; k++) begin
            apply_setting(k);
            no_idle = ($urandom_range(0, 3) == 0);
            random_phase(RANDOM_EDGES / N_PHASES);
            wait_quiet();
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
